// ===== hw/rtl/sldrc_pkg.sv =====
// Package for the slot list delta-run compressor.
// Holds field widths, the controller state type, the command and status
// structs and the bit-count helper. Depends on nothing.
`default_nettype none

package sldrc_pkg;

  // Field widths
  localparam int ID_W    = 16;
  localparam int REP_W   = 6;
  localparam int WORD_W  = 32;
  localparam int SIZE_W  = 8;
  localparam int DBITS_W = 5;
  localparam int LBITS_W = 3;
  localparam int ENT_W   = ID_W + REP_W;
  localparam int ACC_W   = 64;
  localparam int ACC_CW  = 7;

  // Header is first ID (two bytes) plus the bit-count byte
  localparam int HDR_BITS = 24;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_FINISH,
    ST_PREP,
    ST_SIZE,
    ST_STEP,
    ST_APPEND
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic prep;
    logic size_load;
    logic append;
    logic emit_word;
    logic emit_special;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fault;
    logic short_list;
    logic word_ready;
    logic word_last;
    logic runs_left;
    logic out_free;
  } sts_t;

  // Minimum number of bits to hold v, at least one
  function automatic logic [DBITS_W-1:0] min_bits(input logic [ID_W-1:0] v);
    logic [DBITS_W-1:0] n;
    n = DBITS_W'(1);
    for (int i = 1; i < ID_W; i++) begin
      if (v[i]) n = DBITS_W'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sldrc_ctrl.sv =====
// Controller state machine for the slot list delta-run compressor.
// Drives the datapath with sldrc_pkg::cmd_t and reads sldrc_pkg::sts_t.
// Depends on sldrc_pkg.
`default_nettype none

module sldrc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  input  wire logic           in_empty,
  output logic                in_ready,
  input  wire sldrc_pkg::sts_t sts,
  output sldrc_pkg::cmd_t     cmd
);
  import sldrc_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (in_valid && (in_last || in_empty)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!(sts.fault || sts.short_list)) begin
          state_next = ST_PREP;
        end else if (sts.out_free) begin
          state_next = ST_COLLECT;
        end
      end
      ST_PREP: state_next = ST_SIZE;
      ST_SIZE: state_next = ST_STEP;
      ST_STEP: begin
        if (sts.word_ready) begin
          if (sts.out_free && sts.word_last) state_next = ST_COLLECT;
        end else if (sts.runs_left) begin
          state_next = ST_APPEND;
        end else begin
          state_next = ST_COLLECT;
        end
      end
      ST_APPEND: state_next = ST_STEP;
      default: state_next = ST_COLLECT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_COLLECT: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FINISH: begin
        if ((sts.fault || sts.short_list) && sts.out_free) begin
          cmd.emit_special = 1'b1;
          cmd.clear        = 1'b1;
        end
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_SIZE: cmd.size_load = 1'b1;
      ST_STEP: begin
        if (sts.word_ready && sts.out_free) begin
          cmd.emit_word = 1'b1;
          cmd.clear     = sts.word_last;
        end
      end
      ST_APPEND: cmd.append = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sldrc_dp.sv =====
// Datapath for the slot list delta-run compressor: list state, run
// memory, bit packer and output register. Commanded by sldrc_ctrl.
// Depends on sldrc_pkg.
`default_nettype none

module sldrc_dp #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [sldrc_pkg::ID_W-1:0]     in_id,
  input  wire logic                           in_empty,
  input  wire sldrc_pkg::cmd_t                cmd,
  output sldrc_pkg::sts_t                     sts,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [sldrc_pkg::WORD_W-1:0]        out_word,
  output logic                                out_last,
  output logic [sldrc_pkg::SIZE_W-1:0]        out_size,
  output logic                                out_err
);
  import sldrc_pkg::*;

  localparam int RD  = MAX_SLOTS - 1;
  localparam int SCW = $clog2(MAX_SLOTS + 2);
  localparam int RCW = $clog2(RD + 1);
  localparam int RIW = (RD > 1) ? $clog2(RD) : 1;
  localparam int BTW = RCW + DBITS_W;
  localparam logic [SCW-1:0] SC_MAX = SCW'(MAX_SLOTS);
  localparam logic [SCW-1:0] SC_SAT = SCW'(MAX_SLOTS + 1);
  localparam logic [RCW-1:0] RC_MAX = RCW'(RD);

  // List state
  logic [ID_W-1:0]  first_id, first_id_next;
  logic [ID_W-1:0]  prev_id, prev_id_next;
  logic [SCW-1:0]   slot_count, slot_count_next;
  logic [RCW-1:0]   run_count, run_count_next;
  logic [ID_W-1:0]  cur_delta, cur_delta_next;
  logic [REP_W-1:0] cur_repeat, cur_repeat_next;
  logic [ID_W-1:0]  largest_delta, largest_delta_next;
  logic [REP_W-1:0] largest_repeat, largest_repeat_next;
  logic             order_fault, order_fault_next;

  // Run memory
  logic [ENT_W-1:0] run_mem [RD];
  logic             mem_we;
  logic [RIW-1:0]   mem_wa;
  logic [ENT_W-1:0] mem_wd;
  logic [ENT_W-1:0] rd_data;

  // Packer
  logic [DBITS_W-1:0] dbits;
  logic [LBITS_W-1:0] lbits;
  logic [SIZE_W-1:0]  size_bytes;
  logic [ACC_W-1:0]   acc;
  logic [ACC_CW-1:0]  acc_count;
  logic [RCW-1:0]     pk_idx;

  logic [ID_W-1:0]    delta;
  logic [RCW-1:0]     run_dec;
  logic [REP_W-1:0]   cur_inc;
  logic [REP_W-1:0]   lmax;
  logic [DBITS_W-1:0] rbits;
  logic [BTW-1:0]     total_bits;
  logic [ENT_W-1:0]   run_val;

  assign delta   = in_id - prev_id;
  assign run_dec = run_count - RCW'(1);
  assign cur_inc = cur_repeat + REP_W'(1);
  assign lmax    = (cur_repeat > largest_repeat) ? cur_repeat : largest_repeat;
  assign rbits   = dbits + DBITS_W'(lbits);
  assign total_bits = BTW'(run_count) * BTW'(rbits);
  assign run_val = (ENT_W'(rd_data[ENT_W-1:REP_W]) << lbits) | ENT_W'(rd_data[REP_W-1:0]);

  // Next list state and run memory write
  always_comb begin
    first_id_next       = first_id;
    prev_id_next        = prev_id;
    slot_count_next     = slot_count;
    run_count_next      = run_count;
    cur_delta_next      = cur_delta;
    cur_repeat_next     = cur_repeat;
    largest_delta_next  = largest_delta;
    largest_repeat_next = largest_repeat;
    order_fault_next    = order_fault;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (cmd.clear || (cmd.load && in_empty)) begin
      first_id_next       = '0;
      prev_id_next        = '0;
      slot_count_next     = '0;
      run_count_next      = '0;
      cur_delta_next      = '0;
      cur_repeat_next     = '0;
      largest_delta_next  = '0;
      largest_repeat_next = '0;
      order_fault_next    = 1'b0;
    end else if (cmd.load) begin
      if (slot_count == SC_MAX) begin
        slot_count_next = SC_SAT;
      end else if (slot_count < SC_MAX) begin
        if (slot_count == '0) begin
          first_id_next = in_id;
        end else if (slot_count == SCW'(1)) begin
          // Open the first run
          cur_delta_next      = delta;
          cur_repeat_next     = '0;
          run_count_next      = RCW'(1);
          largest_delta_next  = delta;
          largest_repeat_next = '0;
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = {delta, REP_W'(0)};
        end else if (run_count != '0 && run_count <= RC_MAX) begin
          if (delta == cur_delta) begin
            // Extend the current run
            cur_repeat_next = cur_inc;
            mem_we = 1'b1;
            mem_wa = run_dec[RIW-1:0];
            mem_wd = {cur_delta, cur_inc};
          end else if (run_count < RC_MAX) begin
            // Close the current run and open a new one
            if (cur_repeat > largest_repeat) largest_repeat_next = cur_repeat;
            if (in_id < prev_id) order_fault_next = 1'b1;
            if (delta > largest_delta) largest_delta_next = delta;
            cur_delta_next  = delta;
            cur_repeat_next = '0;
            run_count_next  = run_count + RCW'(1);
            mem_we = 1'b1;
            mem_wa = run_count[RIW-1:0];
            mem_wd = {delta, REP_W'(0)};
          end
        end
        prev_id_next    = in_id;
        slot_count_next = slot_count + SCW'(1);
      end
    end
  end

  // List registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_id       <= '0;
      prev_id        <= '0;
      slot_count     <= '0;
      run_count      <= '0;
      cur_delta      <= '0;
      cur_repeat     <= '0;
      largest_delta  <= '0;
      largest_repeat <= '0;
      order_fault    <= 1'b0;
    end else begin
      first_id       <= first_id_next;
      prev_id        <= prev_id_next;
      slot_count     <= slot_count_next;
      run_count      <= run_count_next;
      cur_delta      <= cur_delta_next;
      cur_repeat     <= cur_repeat_next;
      largest_delta  <= largest_delta_next;
      largest_repeat <= largest_repeat_next;
      order_fault    <= order_fault_next;
    end
  end

  // Run memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) run_mem[mem_wa] <= mem_wd;
    if (pk_idx < run_count) rd_data <= run_mem[pk_idx[RIW-1:0]];
  end

  // Bit counts, size, and the packing accumulator
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dbits <= min_bits(largest_delta);
      lbits <= LBITS_W'(min_bits(ID_W'(lmax)));
    end
    if (cmd.size_load) begin
      size_bytes <= SIZE_W'(3 + ((32'(total_bits) + 7) >> 3));
      acc        <= ACC_W'({dbits, lbits, first_id});
      acc_count  <= ACC_CW'(HDR_BITS);
      pk_idx     <= '0;
    end else if (cmd.append) begin
      acc       <= acc | (ACC_W'(run_val) << acc_count);
      acc_count <= acc_count + ACC_CW'(rbits);
      pk_idx    <= pk_idx + RCW'(1);
    end else if (cmd.emit_word) begin
      acc       <= acc >> WORD_W;
      acc_count <= (acc_count >= ACC_CW'(WORD_W)) ? acc_count - ACC_CW'(WORD_W) : '0;
    end
  end

  // Status to the controller
  always_comb begin
    sts.fault      = order_fault || (slot_count > SC_MAX);
    sts.short_list = (slot_count <= SCW'(1));
    sts.runs_left  = (pk_idx < run_count);
    sts.word_ready = (acc_count >= ACC_CW'(WORD_W)) || (!sts.runs_left && acc_count != '0);
    sts.word_last  = !sts.runs_left && (acc_count <= ACC_CW'(WORD_W));
    sts.out_free   = !out_valid || out_ready;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_word || cmd.emit_special) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_word) begin
      out_word <= acc[WORD_W-1:0];
      out_last <= sts.word_last;
      out_size <= size_bytes;
      out_err  <= 1'b0;
    end else if (cmd.emit_special) begin
      out_last <= 1'b1;
      if (sts.fault) begin
        out_word <= '0;
        out_size <= '0;
        out_err  <= 1'b1;
      end else begin
        out_word <= (slot_count == SCW'(1)) ? WORD_W'(first_id) : '0;
        out_size <= (slot_count == SCW'(1)) ? SIZE_W'(2) : '0;
        out_err  <= 1'b0;
      end
    end
  end

  // Checks
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> acc_count < ACC_CW'(WORD_W))
    else $error("run appended with a full word pending");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_word && sts.word_last) |=> slot_count == '0)
    else $error("list state not cleared after final word");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= RC_MAX)
    else $error("run count beyond run memory depth");

  a_err_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |-> (out_size == '0 && out_last))
    else $error("error word with non-zero size or not final");

endmodule

`default_nettype wire

// ===== hw/rtl/slot_list_delta_run_compressor_top.sv =====
// Top level of the slot list delta-run compressor: stream ports and the
// controller and datapath instances. Depends on sldrc_pkg, sldrc_ctrl
// and sldrc_dp.
//
// Slot IDs of a sorted list enter one transfer per cycle while a list is
// being collected; each ID is folded into runs of equal wrapping delta
// held in an internal run memory. The transfer with tlast (or one with
// the empty flag in tuser, which ends the list at once) starts the
// output phase, during which no input is taken. A list that is empty,
// has one slot, is too long or breaks ordering yields one word. Otherwise
// packing first sets up the bit counts, then the size and header, then
// reads each run from the run memory and appends it through the packer,
// one run at a time, sending each 32-bit word once it fills or the runs
// are done, as the single run-memory read port sets the pace; output
// back-pressure stalls the packer. Every word carries the total byte size;
// the final word of a list carries tlast.
`default_nettype none

module slot_list_delta_run_compressor_top #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: [15:0] slot_id
  input  wire logic [15:0] s_axis_tdata,
  // tuser: [0] empty_list
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: [31:0] out_word, [39:32] size_bytes
  output logic [39:0]      m_axis_tdata,
  // tuser: [0] error
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);
  import sldrc_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [WORD_W-1:0] out_word;
  logic [SIZE_W-1:0] out_size;

  sldrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_empty (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sldrc_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_id     (s_axis_tdata),
    .in_empty  (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word),
    .out_last  (m_axis_tlast),
    .out_size  (out_size),
    .out_err   (m_axis_tuser)
  );

  // Pack the output transfer
  assign m_axis_tdata = {out_size, out_word};

endmodule

`default_nettype wire

// ===== dv/slot_list_delta_run_compressor_top_tb.sv =====
// Self-checking testbench for slot_list_delta_run_compressor_top.
// Drives slot lists on the input stream and checks every packed word against
// a delta-run predictor or the directed table. Depends on sldrc_pkg and the top-level RTL only.
`default_nettype none

module slot_list_delta_run_compressor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sldrc_pkg::*;

  localparam int MAX_SLOTS  = 64;
  localparam int RUNS       = MAX_SLOTS - 1;
  localparam int ITEM_GOAL  = 480;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_WAIT  = 40;

  // One output word as the checker sees it
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic [SIZE_W-1:0] size;
    logic              err;
  } packed_word_t;

  // One row of the directed table
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
    logic            empty;
    logic            typed;
    packed_word_t    word;
  } slot_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [15:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              s_axis_tlast = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;

  packed_word_t      pending_words [$];
  packed_word_t      fresh_words [$];
  slot_row_t         directed_rows [$];
  int unsigned       mismatch_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       idle_cycles = 0;
  bit                calm = 1'b0;

  // Predictor copy of the list state
  logic [ID_W-1:0]   first_id_m;
  logic [ID_W-1:0]   prev_id_m;
  int unsigned       n_slots;
  logic [ID_W-1:0]   run_dlt [0:RUNS-1];
  logic [REP_W-1:0]  run_rep [0:RUNS-1];
  int unsigned       n_runs;
  logic [ID_W-1:0]   top_delta;
  logic [REP_W-1:0]  top_repeat;
  bit                order_bad;

  slot_list_delta_run_compressor_top #(
    .MAX_SLOTS(MAX_SLOTS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Return the list state to its idle values
  function automatic void clear_list_state();
    first_id_m = '0;
    prev_id_m  = '0;
    n_slots    = 0;
    n_runs     = 0;
    top_delta  = '0;
    top_repeat = '0;
    order_bad  = 1'b0;
  endfunction

  function automatic int bits_needed(input logic [ID_W-1:0] v);
    for (int n = ID_W; n > 1; n--) begin
      if (v[n-1]) return n;
    end
    return 1;
  endfunction

  // Fold one slot ID into the runs of equal delta
  function automatic void fold_slot(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] d;
    d = id - prev_id_m;
    if (n_slots > MAX_SLOTS) return;
    if (n_slots == MAX_SLOTS) begin
      n_slots = MAX_SLOTS + 1;
      return;
    end
    if (n_slots == 0) begin
      first_id_m = id;
    end else if (n_slots == 1) begin
      run_dlt[0] = d;
      run_rep[0] = '0;
      n_runs     = 1;
      top_delta  = d;
      top_repeat = '0;
    end else if (n_runs >= 1 && n_runs <= RUNS) begin
      if (d == run_dlt[n_runs-1]) begin
        run_rep[n_runs-1] = run_rep[n_runs-1] + 1'b1;
      end else if (n_runs < RUNS) begin
        // ordering is only looked at where a new run opens
        if (run_rep[n_runs-1] > top_repeat) top_repeat = run_rep[n_runs-1];
        if (id < prev_id_m) order_bad = 1'b1;
        run_dlt[n_runs] = d;
        run_rep[n_runs] = '0;
        n_runs++;
        if (d > top_delta) top_delta = d;
      end
    end
    prev_id_m = id;
    n_slots++;
  endfunction

  // Build the packed stream of the finished list into fresh_words
  function automatic void pack_list();
    logic [7:0]        stream_bytes [0:199];
    logic [31:0]       code;
    packed_word_t      w;
    int                lmax, db, lb, rb, total, nwords, pos, base;
    if (order_bad || n_slots > MAX_SLOTS) begin
      w = {32'h0, 1'b1, 8'd0, 1'b1};
      fresh_words.push_back(w);
      return;
    end
    if (n_slots <= 1 || n_runs == 0 || n_runs > RUNS) begin
      w = {(n_slots != 0) ? {16'h0, first_id_m} : 32'h0, 1'b1,
           (n_slots != 0) ? 8'd2 : 8'd0, 1'b0};
      fresh_words.push_back(w);
      return;
    end
    // the last run never passed a run change, so fold it in here
    lmax = top_repeat;
    if (run_rep[n_runs-1] > lmax) lmax = run_rep[n_runs-1];
    db = bits_needed(top_delta);
    lb = bits_needed(16'(lmax));
    rb = db + lb;
    for (int i = 0; i < 200; i++) stream_bytes[i] = 8'h00;
    stream_bytes[0] = first_id_m[7:0];
    stream_bytes[1] = first_id_m[15:8];
    stream_bytes[2] = 8'((db << 3) | (lb & 7));
    pos = 0;
    for (int r = 0; r < n_runs; r++) begin
      code = (32'(run_dlt[r]) << lb) | 32'(run_rep[r]);
      for (int b = 0; b < rb; b++) begin
        if (code[b]) stream_bytes[3 + (pos >> 3)][pos & 7] = 1'b1;
        pos++;
      end
    end
    total  = 3 + (n_runs * rb + 7) / 8;
    nwords = (total + 3) / 4;
    for (int k = 0; k < nwords; k++) begin
      base = k * 4;
      w.word = {stream_bytes[base+3], stream_bytes[base+2],
                stream_bytes[base+1], stream_bytes[base]};
      w.last = (k == nwords - 1);
      w.size = 8'(total);
      w.err  = 1'b0;
      fresh_words.push_back(w);
    end
  endfunction

  // Work out the words one accepted input transfer causes
  function automatic void compress_item(input logic [ID_W-1:0] id, input logic last,
                                        input logic empty);
    packed_word_t w;
    fresh_words.delete();
    if (empty) begin
      clear_list_state();
      w = {32'h0, 1'b1, 8'd0, 1'b0};
      fresh_words.push_back(w);
    end else begin
      fold_slot(id);
      if (last) begin
        pack_list();
        clear_list_state();
      end
    end
  endfunction

  // Mostly short gaps, a few long ones; none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic void add_row(input logic [ID_W-1:0] id, input logic last,
                                  input logic empty, input logic typed,
                                  input packed_word_t word);
    slot_row_t row;
    row = {id, last, empty, typed, word};
    directed_rows.push_back(row);
  endfunction

  // Drive one transfer at the falling edge and hold it until accepted
  task automatic send_slot(input logic [ID_W-1:0] id, input logic last, input logic empty,
                           input logic typed, input packed_word_t word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= id;
    s_axis_tlast  <= last;
    s_axis_tuser  <= empty;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    compress_item(id, last, empty);
    if (typed) pending_words.push_back(word);
    else foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted word has come out
  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One random list: mostly well-formed, the rest broken or noise
  task automatic send_random_list();
    logic [ID_W-1:0] ids [$];
    logic [ID_W-1:0] cur, step, nstep;
    int              pick, len, run_left, drop_at, r;
    bit              distinct, fixed, scramble, cut_by_empty;
    distinct = 1'b0;
    fixed = 1'b0;
    scramble = 1'b0;
    cut_by_empty = 1'b0;
    drop_at = -1;
    calm = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_slot(16'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
      return;
    end
    if (pick < 10) begin
      len = 1;
    end else if (pick < 85) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 12) : $urandom_range(13, 64);
    end else if (pick < 90) begin
      len = $urandom_range(2, 8);
      scramble = 1'b1;
    end else if (pick < 93) begin
      len = $urandom_range(65, 70);
      fixed = 1'b1;
    end else if (pick < 96) begin
      len = MAX_SLOTS;
      fixed = 1'b1;
    end else begin
      len = $urandom_range(60, 64);
      distinct = 1'b1;
    end
    if (pick >= 70 && pick < 80) drop_at = $urandom_range(2, (len > 2) ? len - 1 : 2);
    if (pick >= 80 && pick < 85) cut_by_empty = 1'b1;
    cur = (len <= 12) ? 16'($urandom_range(0, 60000)) : 16'($urandom_range(0, 7000));
    step = fixed ? 16'($urandom_range(1, 900)) : 16'($urandom_range(1, 4));
    run_left = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if (distinct) begin
          do nstep = 16'($urandom_range(1, 900)); while (nstep == step);
          step = nstep;
        end else if (!fixed && run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 40) step = 16'($urandom_range(1, 4));
          else if (r < 75) step = 16'($urandom_range(1, 64));
          else if (r < 92) step = 16'($urandom_range(65, 1024));
          else if (r < 96 && len <= 12) step = 16'($urandom_range(1025, 4000));
          else step = 16'($urandom_range(0, 3));
          run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 30);
        end
        run_left--;
        cur = (i == drop_at) ? cur - 16'($urandom_range(1, 300)) : cur + step;
      end
      ids.push_back(scramble ? 16'($urandom) : cur);
    end
    foreach (ids[i]) send_slot(ids[i], (i == len - 1) && !cut_by_empty, 1'b0, 1'b0, '0);
    if (cut_by_empty) send_slot(16'($urandom), 1'b0, 1'b1, 1'b0, '0);
  endtask

  // Stimulus: reset, directed table, random lists, then the final verdict
  initial begin
    int list_no;
    clear_list_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list, single slots at both extremes, empty with last set
    add_row(16'h1234, 1'b0, 1'b1, 1'b1, {32'h0, 1'b1, 8'd0, 1'b0});
    add_row(16'hFFFF, 1'b1, 1'b0, 1'b1, {32'h0000FFFF, 1'b1, 8'd2, 1'b0});
    add_row(16'h0000, 1'b1, 1'b0, 1'b1, {32'h0, 1'b1, 8'd2, 1'b0});
    add_row(16'hFFFF, 1'b1, 1'b1, 1'b1, {32'h0, 1'b1, 8'd0, 1'b0});
    // one run of delta 4
    add_row(16'd1000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd1004, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd1008, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd1012, 1'b1, 1'b0, 1'b0, '0);
    // first pair falls: wrapped delta, no fault
    add_row(16'd100, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd50, 1'b1, 1'b0, 1'b0, '0);
    // fall at a run change
    add_row(16'd10, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd20, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd15, 1'b1, 1'b0, 1'b1, {32'h0, 1'b1, 8'd0, 1'b1});
    // largest possible delta
    add_row(16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'hFFFF, 1'b1, 1'b0, 1'b0, '0);
    // partial list cut short by the empty flag
    add_row(16'd500, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd600, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'h5A5A, 1'b0, 1'b1, 1'b1, {32'h0, 1'b1, 8'd0, 1'b0});
    // equal IDs: one run of delta zero
    add_row(16'd7, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd7, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd7, 1'b1, 1'b0, 1'b0, '0);
    // falling IDs inside a single run are not checked
    add_row(16'd30, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd20, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd10, 1'b1, 1'b0, 1'b0, '0);

    foreach (directed_rows[i])
      send_slot(directed_rows[i].id, directed_rows[i].last, directed_rows[i].empty,
                directed_rows[i].typed, directed_rows[i].word);
    drain_words();

    // too many slots: run past the bound
    for (int i = 0; i < MAX_SLOTS + 3; i++)
      send_slot(16'(i * 3), i == MAX_SLOTS + 2, 1'b0, 1'b0, '0);

    list_no = 0;
    while (items_sent < ITEM_GOAL) begin
      send_random_list();
      if (list_no % 12 == 11) drain_words();
      list_no++;
    end

    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output back-pressure: random stalls, none in calm stretches
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Compare each output transfer with the oldest predicted word
  always @(posedge clk) begin : check_words
    packed_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_word %h size %0d", m_axis_tdata[31:0], m_axis_tdata[39:32]);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[31:0] !== want.word) begin
          $error("out_word: expected %h, actual %h", want.word, m_axis_tdata[31:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("word_last: expected %b, actual %b", want.last, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tdata[39:32] !== want.size) begin
          $error("size_bytes: expected %0d, actual %0d", want.size, m_axis_tdata[39:32]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.err) begin
          $error("error: expected %b, actual %b", want.err, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

`default_nettype wire
